// ----- rtl/button_click_classifier_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

// ----- rtl/bcc_pkg.sv -----
package bcc_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 2;
  localparam int unsigned EventW = 3;
  localparam int unsigned InDataW  = 40;  // 33 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 8;   // 3 bits of fields, padded to bytes
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxPresses = 2'd3;

  // Reset values of the registers
  localparam logic [MsW-1:0]    DebounceRst   = 16'd50;
  localparam logic [MsW-1:0]    LongPressRst  = 16'd300;
  localparam logic [MsW-1:0]    WindowRst     = 16'd750;
  localparam logic [CountW-1:0] MaxPressesRst = 2'd3;

  // Press count saturates here
  localparam logic [CountW-1:0] PressSat = 2'd3;

  typedef enum logic [EventW-1:0] {
    EV_NONE         = 3'd0,
    EV_PRESSED      = 3'd1,
    EV_SINGLE       = 3'd2,
    EV_DOUBLE       = 3'd3,
    EV_TRIPLE       = 3'd4,
    EV_LONG_RELEASE = 3'd5
  } evt_e;

  typedef struct packed {
    logic [MsW-1:0]    debounce_ms;
    logic [MsW-1:0]    long_press_ms;
    logic [MsW-1:0]    multi_press_window_ms;
    logic [CountW-1:0] max_presses;
  } cfg_t;

endpackage

// ----- rtl/bcc_cfg.sv -----
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce:   cfg_d.debounce_ms           = cfg_wdata_i;
        RegLongPress:  cfg_d.long_press_ms         = cfg_wdata_i;
        RegWindow:     cfg_d.multi_press_window_ms = cfg_wdata_i;
        RegMaxPresses: cfg_d.max_presses           = cfg_wdata_i[CountW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms           <= DebounceRst;
      cfg_q.long_press_ms         <= LongPressRst;
      cfg_q.multi_press_window_ms <= WindowRst;
      cfg_q.max_presses           <= MaxPressesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bcc_core.sv -----
module bcc_core
  import bcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,     // process the item below this cycle
  input  logic [TimeW-1:0] now_time_i,
  input  logic             pin_level_i,
  input  cfg_t             cfg_i,
  output evt_e             event_o
);

  logic              stable_q, stable_d;
  logic [TimeW-1:0]  change_q, change_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              active_q, active_d;
  logic [CountW-1:0] count_q, count_d;
  logic              long_q, long_d;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] since_start;
  logic             level;
  logic             changed;
  evt_e             ev;

  assign since_change = now_time_i - change_q;
  assign since_start  = now_time_i - start_q;

  // Debounce, then classify the press sequence
  always_comb begin
    stable_d = stable_q;
    change_d = change_q;
    start_d  = start_q;
    active_d = active_q;
    count_d  = count_q;
    long_d   = long_q;
    ev       = EV_NONE;

    // Hold the stable level during the hold-off
    if (since_change < {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms}) begin
      level = stable_q;
    end else begin
      level = pin_level_i;
    end
    changed = (level != stable_q);

    if (changed) begin
      change_d = now_time_i;
      stable_d = level;
    end

    if (!level) begin
      if (changed) begin
        if (!active_q) begin
          start_d  = now_time_i;
          active_d = 1'b1;
          count_d  = 2'd1;
          ev       = EV_PRESSED;
        end else if (count_q < PressSat) begin
          count_d = count_q + 2'd1;
        end
      end else if (!long_q &&
                   since_change > {{(TimeW-MsW){1'b0}}, cfg_i.long_press_ms}) begin
        long_d = 1'b1;
      end
    end else if (active_q) begin
      if (!long_q && (count_q >= cfg_i.max_presses ||
          since_start > {{(TimeW-MsW){1'b0}}, cfg_i.multi_press_window_ms})) begin
        case (count_q)
          2'd1:    ev = EV_SINGLE;
          2'd2:    ev = EV_DOUBLE;
          2'd3:    ev = EV_TRIPLE;
          default: ev = EV_NONE;
        endcase
        active_d = 1'b0;
      end else if (long_q) begin
        long_d   = 1'b0;
        active_d = 1'b0;
        ev       = EV_LONG_RELEASE;
      end
    end
  end

  // Advance the sequence state only when an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      change_q <= '0;
      start_q  <= '0;
      active_q <= 1'b0;
      count_q  <= '0;
      long_q   <= 1'b0;
    end else if (step_i) begin
      stable_q <= stable_d;
      change_q <= change_d;
      start_q  <= start_d;
      active_q <= active_d;
      count_q  <= count_d;
      long_q   <= long_d;
    end
  end

  assign event_o = ev;

endmodule

// ----- rtl/button_click_classifier_top.sv -----
// An accepted item is held in the input register, classified from it, and moves into the
// result register once that one is free; m_axis takes it from there.
// Throughput: one item per cycle while m_axis does not stall the result register.
// Reset (rst_ni low, asynchronous): registers return to their defaults, the press
// state clears to released and idle, and both pipeline registers empty.
module button_click_classifier_top
  import bcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [MsW-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [31:0] now_time, [32] pin_level, rest zero
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [2:0] event_code, rest zero
);

  cfg_t             cfg;
  evt_e             ev;
  logic             in_valid_q;
  logic [TimeW-1:0] in_time_q;
  logic             in_pin_q;
  logic             out_valid_q;
  evt_e             out_event_q;
  logic             out_free;
  logic             step;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Move the held item into the result register when that one is free
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  bcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .now_time_i  (in_time_q),
    .pin_level_i (in_pin_q),
    .cfg_i       (cfg),
    .event_o     (ev)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_time_q <= s_axis_tdata[TimeW-1:0];
      in_pin_q  <= s_axis_tdata[TimeW];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_event_q <= ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-EventW){1'b0}}, out_event_q};

endmodule

// ----- rtl/bcc_checker.sv -----
`include "button_click_classifier_top_macros.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result holds its value
  `BCC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Only defined event codes, padding zero
  `BCC_ASSERT_IMP(a_out_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:3] == 5'd0 && m_axis_tdata[2:0] <= 3'd5)

  // Input backpressure only when both stages are full and the output is stalled
  `BCC_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (.*);
